// ----- src/pdfe_pkg.sv -----
// Shared types and character codes for the PDF literal string escaper.
package pdfe_pkg;

    localparam int C_MAX_RUN = 6;

    localparam logic [7:0] C_CH_BSLASH = 8'h5C;
    localparam logic [7:0] C_CH_LPAREN = 8'h28;
    localparam logic [7:0] C_CH_RPAREN = 8'h29;
    localparam logic [7:0] C_CH_NL     = 8'h0A;
    localparam logic [7:0] C_CH_CR     = 8'h0D;
    localparam logic [7:0] C_CH_TAB    = 8'h09;
    localparam logic [7:0] C_CH_BS     = 8'h08;
    localparam logic [7:0] C_CH_FF     = 8'h0C;
    localparam logic [7:0] C_CH_N      = 8'h6E;
    localparam logic [7:0] C_CH_R      = 8'h72;
    localparam logic [7:0] C_CH_T      = 8'h74;
    localparam logic [7:0] C_CH_B      = 8'h62;
    localparam logic [7:0] C_CH_F      = 8'h66;
    localparam logic [7:0] C_CH_ZERO   = 8'h30;
    localparam logic [7:0] C_PRINT_LO  = 8'd32;
    localparam logic [7:0] C_PRINT_HI  = 8'd126;

    typedef logic [2:0] t_run_cnt;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_of_string;
        logic       last_of_string;
        logic       empty_string;
    } t_in_word;

    typedef struct packed {
        logic [C_MAX_RUN-1:0][7:0] bytes;
        t_run_cnt                  cnt;
    } t_run;

endpackage

// ----- src/pdfe_if.sv -----
// Valid/ready channel interfaces for the input and output words.
interface pdfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       first_of_string;
    logic       last_of_string;
    logic       empty_string;

    modport source (
        output valid, byte_value, first_of_string, last_of_string, empty_string,
        input  ready
    );
    modport sink (
        input  valid, byte_value, first_of_string, last_of_string, empty_string,
        output ready
    );
endinterface

interface pdfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (
        output valid, out_byte, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last_of_run,
        output ready
    );
endinterface

// ----- src/pdfe_in_stage.sv -----
// Input register stage that captures one input word per cycle unless a held word is stalled.
module pdfe_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pdfe_in_if.sink            i_in,
    output logic               o_valid,
    output pdfe_pkg::t_in_word o_word,
    input  logic               i_ready
);
    import pdfe_pkg::*;

    logic     r_valid;
    t_in_word r_word;
    logic     take;

    assign i_in.ready = !r_valid || i_ready;
    assign take       = i_in.valid && i_in.ready;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word.byte_value      <= i_in.byte_value;
            r_word.first_of_string <= i_in.first_of_string;
            r_word.last_of_string  <= i_in.last_of_string;
            r_word.empty_string    <= i_in.empty_string;
        end
    end

    // A held word must not change until the serializer takes it.
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_word)))
        else $error("input word changed while stalled");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_valid)
        else $error("accepted word was not registered");

endmodule

// ----- src/pdfe_expand.sv -----
// Combinational expansion of one input word into its escaped byte run.
module pdfe_expand (
    input  pdfe_pkg::t_in_word i_word,
    output pdfe_pkg::t_run     o_run
);
    import pdfe_pkg::*;

    logic [3:0][7:0] esc;
    t_run_cnt        esc_len;
    logic [7:0]      b;
    logic [3:0]      j;
    logic            first;
    logic            last;

    assign b     = i_word.byte_value;
    assign first = i_word.first_of_string;
    assign last  = i_word.last_of_string;

    always_comb begin
        esc     = '0;
        esc_len = 3'd2;
        unique case (b)
            C_CH_BSLASH, C_CH_LPAREN, C_CH_RPAREN: begin
                esc[0] = C_CH_BSLASH;
                esc[1] = b;
            end
            C_CH_NL: begin
                esc[0] = C_CH_BSLASH;
                esc[1] = C_CH_N;
            end
            C_CH_CR: begin
                esc[0] = C_CH_BSLASH;
                esc[1] = C_CH_R;
            end
            C_CH_TAB: begin
                esc[0] = C_CH_BSLASH;
                esc[1] = C_CH_T;
            end
            C_CH_BS: begin
                esc[0] = C_CH_BSLASH;
                esc[1] = C_CH_B;
            end
            C_CH_FF: begin
                esc[0] = C_CH_BSLASH;
                esc[1] = C_CH_F;
            end
            default: begin
                if (b < C_PRINT_LO || b > C_PRINT_HI) begin
                    esc[0]  = C_CH_BSLASH;
                    esc[1]  = C_CH_ZERO | {6'd0, b[7:6]};
                    esc[2]  = C_CH_ZERO | {5'd0, b[5:3]};
                    esc[3]  = C_CH_ZERO | {5'd0, b[2:0]};
                    esc_len = 3'd4;
                end else begin
                    esc[0]  = b;
                    esc_len = 3'd1;
                end
            end
        endcase
    end

    // An empty string yields just the two parentheses; otherwise each output slot is
    // filled independently from the opening flag, the escape bytes and the closing flag.
    always_comb begin
        o_run = '0;
        j     = '0;
        if (i_word.empty_string) begin
            o_run.bytes[0] = C_CH_LPAREN;
            o_run.bytes[1] = C_CH_RPAREN;
            o_run.cnt      = 3'd2;
        end else begin
            for (int k = 0; k < C_MAX_RUN; k++) begin
                j = 4'(k) - {3'd0, first};
                if (first && k == 0) begin
                    o_run.bytes[k] = C_CH_LPAREN;
                end else if (j < {1'b0, esc_len}) begin
                    o_run.bytes[k] = esc[j[1:0]];
                end else if (j == {1'b0, esc_len} && last) begin
                    o_run.bytes[k] = C_CH_RPAREN;
                end
            end
            o_run.cnt = {2'd0, first} + esc_len + {2'd0, last};
        end
    end

endmodule

// ----- src/pdfe_serializer.sv -----
// Shift register that sends an expanded run out one byte per cycle while the output is ready.
module pdfe_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  pdfe_pkg::t_run  i_run,
    output logic            o_ready,
    pdfe_out_if.source      o_out
);
    import pdfe_pkg::*;

    logic                      r_valid;
    logic [C_MAX_RUN-1:0][7:0] r_seq;
    t_run_cnt                  r_cnt;
    logic                      last_taken;
    logic                      load;

    // The next run loads in the same cycle that the last byte of this one leaves.
    assign last_taken = r_valid && o_out.ready && r_cnt == 3'd1;
    assign o_ready    = !r_valid || last_taken;
    assign load       = i_valid && o_ready;

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_seq[0];
    assign o_out.last_of_run = r_cnt == 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (last_taken) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_seq <= i_run.bytes;
            r_cnt <= i_run.cnt;
        end else if (r_valid && o_out.ready && r_cnt != 3'd1) begin
            r_seq <= {8'h00, r_seq[C_MAX_RUN-1:1]};
            r_cnt <= r_cnt - 3'd1;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_cnt != 3'd0 && r_cnt <= 3'(C_MAX_RUN)))
        else $error("run count out of range");

    a_shift_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_out.ready && r_cnt != 3'd1) |=>
            (r_valid && r_cnt == $past(r_cnt) - 3'd1))
        else $error("run did not advance by one byte");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_valid && r_cnt == $past(i_run.cnt)))
        else $error("loaded run has wrong length");

endmodule

// ----- src/pdfe_top.sv -----
// Escapes raw string bytes into PDF literal string syntax.
// Each input word expands to one to six output words (parentheses, backslash
// escapes, three-digit octal escapes), sent one word per cycle while the sink
// is ready. The output shift register sets the rate: all bytes of a run
// leave before the next run loads, so input words are taken every cycle as
// long as each expands to a single byte and the sink is ready. The next run
// is loaded in the cycle its predecessor's last byte leaves, so no gap appears
// between runs. Words pass the input register, then the output shift register.
module pdf_literal_string_escaper_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdfe_in_if.sink     i_in,
    pdfe_out_if.source  o_out
);
    import pdfe_pkg::*;

    logic     stage_valid;
    t_in_word stage_word;
    logic     ser_ready;
    t_run     run;

    pdfe_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (stage_valid),
        .o_word  (stage_word),
        .i_ready (ser_ready)
    );

    pdfe_expand u_expand (
        .i_word (stage_word),
        .o_run  (run)
    );

    pdfe_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid),
        .i_run   (run),
        .o_ready (ser_ready),
        .o_out   (o_out)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the PDF literal string escaper.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdfe_pkg::*;

    localparam int C_HOLD_CYCLES  = 80;
    localparam int C_STALL_LIMIT  = 1000;
    localparam int C_PHASE_WORDS  = 33;
    localparam int C_DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_word;

    typedef struct packed {
        t_in_word word;
        logic     has_typed;
        t_run     typed;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    pdfe_in_if  in_ch();
    pdfe_out_if out_ch();

    pdf_literal_string_escaper_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_out_word escaped_bytes_due[$];
    t_stim_row directed_rows[$];

    int error_count = 0;
    int words_in    = 0;
    int words_typed = 0;
    int bytes_out   = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;
    int idle_cycles = 0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Appends one byte to an expected run.
    function automatic void put_byte(inout t_run r, input logic [7:0] v);
        r.bytes[r.cnt] = v;
        r.cnt          = r.cnt + 3'd1;
    endfunction

    // Expected escape sequence of one input word.
    function automatic t_run escape_word(t_in_word w);
        t_run       run;
        logic [7:0] b;
        logic [7:0] letter;
        b   = w.byte_value;
        run = '0;
        case (b)
            C_CH_NL:  letter = C_CH_N;
            C_CH_CR:  letter = C_CH_R;
            C_CH_TAB: letter = C_CH_T;
            C_CH_BS:  letter = C_CH_B;
            C_CH_FF:  letter = C_CH_F;
            default:  letter = 8'h00;
        endcase
        if (w.empty_string) begin
            put_byte(run, C_CH_LPAREN);
            put_byte(run, C_CH_RPAREN);
        end else begin
            if (w.first_of_string) put_byte(run, C_CH_LPAREN);
            if (b == C_CH_BSLASH || b == C_CH_LPAREN || b == C_CH_RPAREN) begin
                put_byte(run, C_CH_BSLASH);
                put_byte(run, b);
            end else if (letter != 8'h00) begin
                put_byte(run, C_CH_BSLASH);
                put_byte(run, letter);
            end else if (b < C_PRINT_LO || b > C_PRINT_HI) begin
                put_byte(run, C_CH_BSLASH);
                put_byte(run, C_CH_ZERO + {6'd0, b[7:6]});
                put_byte(run, C_CH_ZERO + {5'd0, b[5:3]});
                put_byte(run, C_CH_ZERO + {5'd0, b[2:0]});
            end else begin
                put_byte(run, b);
            end
            if (w.last_of_string) put_byte(run, C_CH_RPAREN);
        end
        return run;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    // An empty expectation string means the row is checked against escape_word.
    task automatic add_row(logic [7:0] b, bit first, bit last, bit empty, string typed);
        t_stim_row row;
        row = '0;
        row.word.byte_value      = b;
        row.word.first_of_string = first;
        row.word.last_of_string  = last;
        row.word.empty_string    = empty;
        row.has_typed = (typed.len() != 0);
        for (int i = 0; i < typed.len(); i++) row.typed.bytes[i] = typed[i];
        row.typed.cnt = t_run_cnt'(typed.len());
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Offers one word, waits for the handshake and records what it must produce.
    task automatic send_word(t_in_word w, logic has_typed, t_run typed);
        t_run      run;
        t_out_word due;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.byte_value      <= w.byte_value;
        in_ch.first_of_string <= w.first_of_string;
        in_ch.last_of_string  <= w.last_of_string;
        in_ch.empty_string    <= w.empty_string;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        run = has_typed ? typed : escape_word(w);
        for (int i = 0; i < run.cnt; i++) begin
            due.out_byte    = run.bytes[i];
            due.last_of_run = (i == run.cnt - 1);
            escaped_bytes_due.insert(escaped_bytes_due.size(), due);
        end
        words_in++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'($urandom_range(C_PRINT_HI, C_PRINT_LO));
            4: begin
                case ($urandom_range(7))
                    0: return C_CH_BSLASH;
                    1: return C_CH_LPAREN;
                    2: return C_CH_RPAREN;
                    3: return C_CH_NL;
                    4: return C_CH_CR;
                    5: return C_CH_TAB;
                    6: return C_CH_BS;
                    default: return C_CH_FF;
                endcase
            end
            5, 6: return 8'($urandom_range(C_PRINT_LO - 1, 0));
            default: return 8'($urandom_range(255, C_PRINT_HI + 1));
        endcase
    endfunction

    // A well-formed string flagged first/last at its ends; len 0 sends one empty word.
    task automatic send_string(int len);
        t_in_word w;
        if (len == 0) begin
            w.byte_value      = 8'($urandom_range(255));
            w.first_of_string = 1'($urandom_range(1));
            w.last_of_string  = 1'($urandom_range(1));
            w.empty_string    = 1'b1;
            send_word(w, 1'b0, '0);
        end else begin
            for (int i = 0; i < len; i++) begin
                w.byte_value      = pick_byte();
                w.first_of_string = (i == 0);
                w.last_of_string  = (i == len - 1);
                w.empty_string    = 1'b0;
                send_word(w, 1'b0, '0);
            end
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = C_HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            bytes_out++;
            if (escaped_bytes_due.size() == 0) begin
                report_error($sformatf("unexpected word: byte 8'h%02h last %0b",
                                       out_ch.out_byte, out_ch.last_of_run));
            end else begin
                want = escaped_bytes_due.pop_front();
                if (out_ch.out_byte !== want.out_byte)
                    report_error($sformatf("out_byte 8'h%02h, want 8'h%02h",
                                           out_ch.out_byte, want.out_byte));
                if (out_ch.last_of_run !== want.last_of_run)
                    report_error($sformatf("last_of_run %0b, want %0b (byte 8'h%02h)",
                                           out_ch.last_of_run, want.last_of_run,
                                           want.out_byte));
            end
        end
    end

    // Ends the run if neither channel moves a word for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= C_STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", C_STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int tx_pct[3];
        int rx_pct[3];
        int phase_start;
        t_in_word w;

        tx_pct = '{29, 59, 0};
        rx_pct = '{59, 29, 0};

        i_rst_n               <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.byte_value      <= 8'h00;
        in_ch.first_of_string <= 1'b0;
        in_ch.last_of_string  <= 1'b0;
        in_ch.empty_string    <= 1'b0;

        add_row(8'hFF,       1, 1, 1, "()");
        add_row(8'h00,       0, 0, 1, "()");
        add_row(8'h00,       1, 1, 0, "(\\000)");
        add_row(8'hFF,       0, 0, 0, "\\377");
        add_row(8'h41,       0, 0, 0, "A");
        add_row(C_PRINT_LO,  1, 0, 0, "");
        add_row(C_PRINT_HI,  0, 1, 0, "");
        add_row(8'h1F,       0, 0, 0, "");
        add_row(8'h7F,       0, 0, 0, "");
        add_row(8'h80,       1, 1, 0, "");
        add_row(C_CH_BSLASH, 1, 0, 0, "");
        add_row(C_CH_LPAREN, 0, 0, 0, "");
        add_row(C_CH_RPAREN, 0, 1, 0, "");
        add_row(C_CH_NL,     1, 1, 0, "");
        add_row(C_CH_CR,     0, 0, 0, "");
        add_row(C_CH_TAB,    1, 0, 0, "");
        add_row(C_CH_BS,     0, 1, 0, "");
        add_row(C_CH_FF,     0, 0, 0, "");
        add_row(8'h0B,       0, 0, 0, "");
        add_row(8'hAA,       0, 0, 0, "");
        add_row(8'h55,       1, 0, 0, "");

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = tx_pct[p];
            rx_idle_pct = rx_pct[p];
            if (p == 0) begin
                foreach (directed_rows[i]) begin
                    send_word(directed_rows[i].word, directed_rows[i].has_typed,
                              directed_rows[i].typed);
                    if (directed_rows[i].has_typed) words_typed++;
                end
            end
            // With no idling, the output is held off so the input backs up.
            if (p == 2) hold_req = 1'b1;
            phase_start = words_in;
            while (words_in - phase_start < C_PHASE_WORDS) begin
                if ($urandom_range(9) == 0) begin
                    w.byte_value      = 8'($urandom_range(255));
                    w.first_of_string = 1'($urandom_range(1));
                    w.last_of_string  = 1'($urandom_range(1));
                    w.empty_string    = ($urandom_range(3) == 0);
                    send_word(w, 1'b0, '0);
                end else begin
                    send_string($urandom_range(6));
                end
            end
        end
        in_ch.valid <= 1'b0;

        while (escaped_bytes_due.size() != 0) @(posedge i_clk);
        repeat (C_DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (%0d directed, %0d with typed results), checked %0d bytes;",
                 words_in, directed_rows.size(), words_typed, bytes_out);
        $display("three idle patterns plus one %0d-cycle output hold-off, %0d errors.",
                 C_HOLD_CYCLES, error_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/pdfe_pkg.sv
src/pdfe_if.sv
src/pdfe_in_stage.sv
src/pdfe_expand.sv
src/pdfe_serializer.sv
src/pdfe_top.sv
sim/tb.sv
